FILE: design/opd_pkg.sv
package opd_pkg;

    // Page header layout
    localparam logic [31:0] CAPTURE_PATTERN = 32'h5367674F;
    localparam logic [7:0]  OGG_VERSION     = 8'h00;
    localparam logic [4:0]  HEADER_LEN      = 5'd27;
    localparam logic [4:0]  SEG_COUNT_POS   = 5'd26;
    localparam logic [4:0]  VERSION_POS     = 5'd4;
    localparam logic [4:0]  CAPTURE_LEN     = 5'd4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CAPTURE = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_PREMATURE   = 2'd3
    } opd_status_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_TABLE   = 3'b010,
        PH_PAYLOAD = 3'b100
    } opd_phase_t;

    // One result from the parser toward the output register
    typedef struct packed {
        logic        vld;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        page_end;
        opd_status_t status;
    } opd_result_t;

    // Expected capture byte at header position 0..3
    function automatic logic [7:0] capture_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CAPTURE_PATTERN[7:0];
            2'd1:    b = CAPTURE_PATTERN[15:8];
            2'd2:    b = CAPTURE_PATTERN[23:16];
            default: b = CAPTURE_PATTERN[31:24];
        endcase
        return b;
    endfunction

endpackage

FILE: design/opd_parser.sv
module opd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data,
    input  logic                last,
    output opd_pkg::opd_result_t res
);
    import opd_pkg::*;

    opd_phase_t  phase_reg, phase_next;
    logic [4:0]  hpos_reg, hpos_next;
    logic [7:0]  table_left_reg, table_left_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic        halted_reg, halted_next;

    logic [4:0]  hpos;
    logic [15:0] sum;
    logic [7:0]  tl_dec;

    // Next state and result for the byte in the input register
    always_comb
    begin
        phase_next        = phase_reg;
        hpos_next         = hpos_reg;
        table_left_next   = table_left_reg;
        payload_left_next = payload_left_reg;
        halted_next       = halted_reg;
        res               = '{vld: 1'b0, payload_byte: 8'd0, byte_valid: 1'b0,
                              page_end: 1'b0, status: ST_OK};
        hpos   = (hpos_reg >= HEADER_LEN) ? 5'd0 : hpos_reg;
        sum    = payload_left_reg + {8'd0, data};
        tl_dec = table_left_reg - 8'd1;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (payload_left_reg <= 16'd1)
                    begin
                        payload_left_next = 16'd0;
                        phase_next        = PH_HEADER;
                        hpos_next         = 5'd0;
                        res = '{1'b1, data, 1'b1, 1'b1, ST_OK};
                    end
                    else if (last)
                    begin
                        halted_next = 1'b1;
                        res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_PREMATURE};
                    end
                    else
                    begin
                        payload_left_next = payload_left_reg - 16'd1;
                        res = '{1'b1, data, 1'b1, 1'b0, ST_OK};
                    end
                end
                PH_TABLE:
                begin
                    payload_left_next = sum;
                    table_left_next   = tl_dec;
                    if (tl_dec != 8'd0)
                    begin
                        if (last)
                        begin
                            halted_next = 1'b1;
                            res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_PREMATURE};
                        end
                    end
                    else if (sum == 16'd0)
                    begin
                        phase_next = PH_HEADER;
                        hpos_next  = 5'd0;
                        res = '{1'b1, 8'd0, 1'b0, 1'b1, ST_OK};
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        if (last)
                        begin
                            halted_next = 1'b1;
                            res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_PREMATURE};
                        end
                    end
                end
                default:
                begin
                    // Header phase, also taken by any unused phase code
                    phase_next = PH_HEADER;
                    hpos_next  = hpos;
                    if (hpos == SEG_COUNT_POS)
                    begin
                        hpos_next         = 5'd0;
                        payload_left_next = 16'd0;
                        if (data == 8'd0)
                        begin
                            res = '{1'b1, 8'd0, 1'b0, 1'b1, ST_OK};
                        end
                        else
                        begin
                            table_left_next = data;
                            phase_next      = PH_TABLE;
                            if (last)
                            begin
                                halted_next = 1'b1;
                                res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_PREMATURE};
                            end
                        end
                    end
                    else if (last)
                    begin
                        halted_next = 1'b1;
                        res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_PREMATURE};
                    end
                    else if (hpos < CAPTURE_LEN && data != capture_byte(hpos[1:0]))
                    begin
                        halted_next = 1'b1;
                        res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_BAD_CAPTURE};
                    end
                    else if (hpos == VERSION_POS && data != OGG_VERSION)
                    begin
                        halted_next = 1'b1;
                        res = '{1'b1, 8'd0, 1'b0, 1'b0, ST_BAD_VERSION};
                    end
                    else
                    begin
                        hpos_next = hpos + 5'd1;
                    end
                end
            endcase
        end
    end

    // Advance parser state when a byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            hpos_reg         <= 5'd0;
            table_left_reg   <= 8'd0;
            payload_left_reg <= 16'd0;
            halted_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            hpos_reg         <= hpos_next;
            table_left_reg   <= table_left_next;
            payload_left_reg <= payload_left_next;
            halted_reg       <= halted_next;
        end
    end

endmodule

FILE: design/ogg_page_deframer.sv
// Ogg page deframer.
// Input channel (in_valid / in_ready): one file byte per transaction on data_byte, with
// stream_end high on the final byte of the file.
// Output channel (out_valid / out_ready): payload bytes of each page, one per transaction,
// byte_valid high and page_end high on the last byte of the page. A page with no payload
// gives a single transaction with byte_valid low and page_end high. Header and segment
// table bytes give no transaction.
// Errors (bad capture pattern, bad version, end of stream inside a page) give one
// transaction with the status code; after that the block swallows all input and sends
// nothing until reset.
// A byte accepted into the input register is parsed out of it combinationally and its
// result is loaded into the result register when the byte moves on. Throughput: one byte per
// cycle while the output is not stalled, set by the single pass of counter and
// compare logic between the two registers.
// Reset clears the valid bits of both registers and puts the parser at the start of a page header.
// When out_ready is low and a result waits, the result register holds and the byte in the
// input register waits behind it, whether or not it gives a result; with a byte held, in_ready
// then stays low until the waiting result is taken.
module ogg_page_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       byte_valid,
    output logic       page_end,
    output logic [1:0] status
);
    import opd_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  data_reg;
    logic        end_reg;
    logic        out_vld_reg;
    logic [7:0]  payload_reg;
    logic        bvalid_reg;
    logic        pend_reg;
    logic [1:0]  status_reg;
    logic        step;
    opd_result_t res;

    // Move the held byte on when the result register is free or being emptied
    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            end_reg  <= stream_end;
        end
    end

    opd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .data  (data_reg),
        .last  (end_reg),
        .res   (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step && res.vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.vld)
        begin
            payload_reg <= res.payload_byte;
            bvalid_reg  <= res.byte_valid;
            pend_reg    <= res.page_end;
            status_reg  <= res.status;
        end
    end

    assign out_valid    = out_vld_reg;
    assign payload_byte = payload_reg;
    assign byte_valid   = bvalid_reg;
    assign page_end     = pend_reg;
    assign status       = status_reg;

endmodule

FILE: design/opd_checker.sv
module opd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] payload_byte,
    input logic       byte_valid,
    input logic       page_end,
    input logic [1:0] status
);
    import opd_pkg::*;

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte)
            && $stable(byte_valid) && $stable(page_end) && $stable(status))
    else $error("stalled result changed");

    // Error results carry no byte and no page end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !byte_valid && !page_end && payload_byte == 8'd0)
    else $error("error result carries payload");

    // A result without a byte is an empty page marker or an error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid && status == ST_OK |-> page_end && payload_byte == 8'd0)
    else $error("empty result without page end");

    // Nothing follows a delivered error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && status != ST_OK |=> !out_valid)
    else $error("result after error");

    // Input is open while no result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

endmodule

bind ogg_page_deframer opd_checker u_opd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .page_end     (page_end),
    .status       (status)
);
